// ===== rtl/core/ulj_pkg.sv =====
package ulj_pkg;

    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SERVER_ROLE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SENDER_STREAM = 1'd1;

    localparam logic [31:0] CONNECT_WORD = 32'h3637_3839;
    localparam logic [31:0] REPLY_WORD   = 32'h3938_3736;

    localparam logic [29:0] NS_PER_S  = 30'd1_000_000_000;
    localparam logic [9:0]  NS_PER_US = 10'd1000;

    localparam int unsigned ACC_W = 40;
    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam int unsigned MIN_WORD_LEN  = 4;
    localparam int unsigned MIN_COUNT_LEN = 16;

    localparam logic [1:0] CLS_IN_ORDER = 2'd0;
    localparam logic [1:0] CLS_GAP      = 2'd1;
    localparam logic [1:0] CLS_FILL     = 2'd2;
    localparam logic [1:0] CLS_DUP      = 2'd3;

    // queue depths between the parts
    localparam int unsigned MQ_DEPTH = 2;
    localparam int unsigned MQ_PTR_W = $clog2(MQ_DEPTH);
    localparam int unsigned MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int unsigned RQ_DEPTH = 2;
    localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    typedef struct packed {
        logic [31:0] first_word;
        logic [15:0] length;
        logic [31:0] sent_seconds;
        logic [31:0] sent_micros;
        logic [31:0] sequence_req;
        logic [63:0] arrival_ns;
        logic        omitting;
    } in_item_t;

    typedef struct packed {
        logic        send_reply;
        logic        begin_sending;
        logic        counted;
        logic [1:0]  class_code;
        logic [31:0] lost_total;
        logic [31:0] reorder_total;
        logic [31:0] duplicate_total;
        logic [63:0] packet_total;
        logic [63:0] byte_total;
        logic [31:0] jitter_ns;
        logic [31:0] first_sequence;
        logic [31:0] highest_sequence;
    } result_t;

    // classified request handed from front to back
    typedef struct packed {
        logic        reply;
        logic        begin_tx;
        logic        count;
        logic [31:0] seq;
        logic [15:0] len;
        logic [63:0] transit;
    } mid_entry_t;

    function automatic logic [31:0] swap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic word_is(input logic [31:0] w, input logic [31:0] key);
        return (w == key) || (swap32(w) == key);
    endfunction

endpackage

// ===== rtl/core/udp_receive_loss_jitter_monitor.sv =====
// Channel   | Handshake              | Payload
// ----------+------------------------+------------------------------------
// input     | push / full            | item   (in_item_t)
// results   | empty / pop            | result (result_t), oldest first
// config    | cfg_valid / cfg_ready  | cfg_index, cfg_data[0]
//
// One result per request. The back end handles one request at a time in two steps
// (take and classify, then update counters and jitter) before taking the next; a
// request passes the front register, mid queue, back end and result queue in order.
// The front stage computes the sender time products and transit; a two-entry
// queue separates it from the back end, and a two-entry result queue absorbs
// short pop stalls before input backs up. Reset clears all statistics and config.
module udp_receive_loss_jitter_monitor
    import ulj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    logic       mid_valid;
    mid_entry_t mid_entry;
    logic       mid_pop;
    logic       res_full;
    logic       res_push;
    result_t    res_data;

    assign cfg_ready = 1'b1;

    ulj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mid_valid (mid_valid),
        .mid_entry (mid_entry),
        .mid_pop   (mid_pop)
    );

    ulj_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_valid (mid_valid),
        .mid_entry (mid_entry),
        .mid_pop   (mid_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    ulj_resq u_resq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_data (res_data),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ===== rtl/core/ulj_front.sv =====
module ulj_front
    import ulj_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 mid_valid,
    output mid_entry_t           mid_entry,
    input  logic                 mid_pop
);

    logic server_role_reg, server_role_next;
    logic sender_stream_reg, sender_stream_next;

    logic        s1_valid_reg, s1_valid_next;
    logic        s1_reply_reg, s1_begin_reg, s1_count_reg;
    logic [31:0] s1_seq_reg;
    logic [15:0] s1_len_reg;
    logic [63:0] s1_arr_reg;
    logic [61:0] s1_ps_reg;
    logic [41:0] s1_pu_reg;

    logic        accept;
    logic        adv;
    logic        is_word;
    logic        reply_c, begin_c, count_c;
    logic [61:0] prod_s;
    logic [41:0] prod_u;
    logic [63:0] sent_ns;

    mid_entry_t            mq_mem [MQ_DEPTH];
    logic [MQ_PTR_W-1:0]   mq_wr_reg, mq_wr_next;
    logic [MQ_PTR_W-1:0]   mq_rd_reg, mq_rd_next;
    logic [MQ_CNT_W-1:0]   mq_cnt_reg, mq_cnt_next;
    logic                  mq_full;
    logic                  mq_push;
    mid_entry_t            mq_in;

    // config decode
    always_comb
    begin
        server_role_next   = server_role_reg;
        sender_stream_next = sender_stream_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SERVER_ROLE:   server_role_next   = cfg_data[0];
                REG_SENDER_STREAM: sender_stream_next = cfg_data[0];
                default: ;
            endcase
        end
    end

    assign mq_full = (mq_cnt_reg == MQ_CNT_W'(MQ_DEPTH));
    assign full    = s1_valid_reg && mq_full;
    assign accept  = push && !full;
    assign adv     = !s1_valid_reg || !mq_full;
    assign mq_push = s1_valid_reg && !mq_full;

    // classify on entry
    assign is_word = (item.length >= 16'(MIN_WORD_LEN)) &&
                     (server_role_reg ? word_is(item.first_word, CONNECT_WORD)
                                      : word_is(item.first_word, REPLY_WORD));
    assign reply_c = server_role_reg && is_word;
    assign begin_c = !server_role_reg && is_word;
    assign count_c = !is_word && !sender_stream_reg && !item.omitting &&
                     (item.length >= 16'(MIN_COUNT_LEN));

    assign prod_s = 62'(item.sent_seconds) * 62'(NS_PER_S);
    assign prod_u = 42'(item.sent_micros) * 42'(NS_PER_US);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (adv)
        begin
            s1_valid_next = accept;
        end
    end

    assign sent_ns = 64'(s1_ps_reg) + 64'(s1_pu_reg);

    always_comb
    begin
        mq_in.reply    = s1_reply_reg;
        mq_in.begin_tx = s1_begin_reg;
        mq_in.count    = s1_count_reg;
        mq_in.seq      = s1_seq_reg;
        mq_in.len      = s1_len_reg;
        mq_in.transit  = s1_arr_reg - sent_ns;
    end

    always_comb
    begin
        mq_wr_next  = mq_wr_reg;
        mq_rd_next  = mq_rd_reg;
        mq_cnt_next = mq_cnt_reg;
        if (mq_push)
        begin
            mq_wr_next = (mq_wr_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : mq_wr_reg + 1'b1;
        end
        if (mid_pop)
        begin
            mq_rd_next = (mq_rd_reg == MQ_PTR_W'(MQ_DEPTH - 1)) ? '0 : mq_rd_reg + 1'b1;
        end
        if (mq_push && !mid_pop)
        begin
            mq_cnt_next = mq_cnt_reg + 1'b1;
        end
        else if (!mq_push && mid_pop)
        begin
            mq_cnt_next = mq_cnt_reg - 1'b1;
        end
    end

    assign mid_valid = (mq_cnt_reg != '0);
    assign mid_entry = mq_mem[mq_rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_role_reg   <= 1'b0;
            sender_stream_reg <= 1'b0;
            s1_valid_reg      <= 1'b0;
            mq_wr_reg         <= '0;
            mq_rd_reg         <= '0;
            mq_cnt_reg        <= '0;
        end
        else
        begin
            server_role_reg   <= server_role_next;
            sender_stream_reg <= sender_stream_next;
            s1_valid_reg      <= s1_valid_next;
            mq_wr_reg         <= mq_wr_next;
            mq_rd_reg         <= mq_rd_next;
            mq_cnt_reg        <= mq_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && accept)
        begin
            s1_reply_reg <= reply_c;
            s1_begin_reg <= begin_c;
            s1_count_reg <= count_c;
            s1_seq_reg   <= item.sequence_req;
            s1_len_reg   <= item.length;
            s1_arr_reg   <= item.arrival_ns;
            s1_ps_reg    <= prod_s;
            s1_pu_reg    <= prod_u;
        end
        if (mq_push)
        begin
            mq_mem[mq_wr_reg] <= mq_in;
        end
    end

endmodule

// ===== rtl/core/ulj_back.sv =====
module ulj_back
    import ulj_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mid_valid,
    input  mid_entry_t mid_entry,
    output logic       mid_pop,
    input  logic       res_full,
    output logic       res_push,
    output result_t    res_data
);

    localparam logic ST_TAKE   = 1'b0;
    localparam logic ST_FINISH = 1'b1;

    logic state_reg, state_next;

    logic             have_first_reg, have_first_next;
    logic [31:0]      expected_reg, expected_next;
    logic [31:0]      first_reg, first_next;
    logic [31:0]      top_reg, top_next;
    logic [31:0]      lost_reg, lost_next;
    logic [31:0]      reorder_reg, reorder_next;
    logic [31:0]      dup_reg, dup_next;
    logic [63:0]      pkt_reg, pkt_next;
    logic [63:0]      octet_reg, octet_next;
    logic [63:0]      prev_reg, prev_next;
    logic [ACC_W-1:0] acc_reg, acc_next;

    logic             reply_reg, reply_next;
    logic             begin_reg, begin_next;
    logic             counted_reg, counted_next;
    logic [1:0]       cls_reg, cls_next;
    logic [31:0]      gap_reg, gap_next;
    logic [ACC_W-1:0] mag_reg, mag_next;
    logic [ACC_W-1:0] dec_reg, dec_next;
    logic             jupd_reg, jupd_next;

    logic [31:0]      exp_eff;
    logic             in_order, ahead;
    logic [63:0]      diff_pos, diff_neg, mag_full;
    logic [ACC_W-1:0] mag_sat;
    logic [ACC_W:0]   acc_sum;
    logic [ACC_W-1:0] acc_sat;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    assign exp_eff  = have_first_reg ? expected_reg : mid_entry.seq;
    assign in_order = (mid_entry.seq == exp_eff);
    assign ahead    = (mid_entry.seq > exp_eff);

    assign diff_pos = mid_entry.transit - prev_reg;
    assign diff_neg = prev_reg - mid_entry.transit;
    assign mag_full = diff_pos[63] ? diff_neg : diff_pos;
    assign mag_sat  = (mag_full[63:ACC_W] != '0) ? ACC_MAX : mag_full[ACC_W-1:0];

    assign acc_sum = {1'b0, dec_reg} + {1'b0, mag_reg};
    assign acc_sat = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        have_first_next = have_first_reg;
        expected_next   = expected_reg;
        first_next      = first_reg;
        top_next        = top_reg;
        lost_next       = lost_reg;
        reorder_next    = reorder_reg;
        dup_next        = dup_reg;
        pkt_next        = pkt_reg;
        octet_next      = octet_reg;
        prev_next       = prev_reg;
        acc_next        = acc_reg;
        reply_next      = reply_reg;
        begin_next      = begin_reg;
        counted_next    = counted_reg;
        cls_next        = cls_reg;
        gap_next        = gap_reg;
        mag_next        = mag_reg;
        dec_next        = dec_reg;
        jupd_next       = jupd_reg;
        mid_pop         = 1'b0;
        res_push        = 1'b0;

        unique case (state_reg)
            ST_TAKE:
            begin
                if (mid_valid)
                begin
                    mid_pop      = 1'b1;
                    state_next   = ST_FINISH;
                    reply_next   = mid_entry.reply;
                    begin_next   = mid_entry.begin_tx;
                    counted_next = mid_entry.count;
                    cls_next     = CLS_IN_ORDER;
                    gap_next     = mid_entry.seq - exp_eff;
                    mag_next     = mag_sat;
                    dec_next     = acc_reg - (acc_reg >> 4);
                    jupd_next    = have_first_reg;
                    if (mid_entry.count)
                    begin
                        have_first_next = 1'b1;
                        if (!have_first_reg)
                        begin
                            first_next = mid_entry.seq;
                        end
                        if (mid_entry.seq > top_reg)
                        begin
                            top_next = mid_entry.seq;
                        end
                        pkt_next   = pkt_reg + 64'd1;
                        octet_next = octet_reg + 64'(mid_entry.len);
                        prev_next  = mid_entry.transit;
                        if (in_order || ahead)
                        begin
                            cls_next      = in_order ? CLS_IN_ORDER : CLS_GAP;
                            expected_next = mid_entry.seq + 32'd1;
                        end
                        else
                        begin
                            cls_next      = (lost_reg != '0) ? CLS_FILL : CLS_DUP;
                            expected_next = exp_eff;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                // hold until the result queue has room
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = ST_TAKE;
                    if (counted_reg)
                    begin
                        unique case (cls_reg)
                            CLS_GAP:  lost_next = sat_add32(lost_reg, gap_reg);
                            CLS_FILL:
                            begin
                                lost_next    = lost_reg - 32'd1;
                                reorder_next = sat_add32(reorder_reg, 32'd1);
                            end
                            CLS_DUP:  dup_next = sat_add32(dup_reg, 32'd1);
                            default: ;
                        endcase
                        if (jupd_reg)
                        begin
                            acc_next = acc_sat;
                        end
                    end
                end
            end
            default: state_next = ST_TAKE;
        endcase
    end

    always_comb
    begin
        res_data.send_reply       = reply_reg;
        res_data.begin_sending    = begin_reg;
        res_data.counted          = counted_reg;
        res_data.class_code       = counted_reg ? cls_reg : CLS_IN_ORDER;
        res_data.lost_total       = lost_next;
        res_data.reorder_total    = reorder_next;
        res_data.duplicate_total  = dup_next;
        res_data.packet_total     = pkt_reg;
        res_data.byte_total       = octet_reg;
        res_data.jitter_ns        = (acc_next[ACC_W-1:36] != '0) ? 32'hFFFF_FFFF
                                                                 : acc_next[35:4];
        res_data.first_sequence   = first_reg;
        res_data.highest_sequence = top_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_TAKE;
            have_first_reg <= 1'b0;
            expected_reg   <= '0;
            first_reg      <= '0;
            top_reg        <= '0;
            lost_reg       <= '0;
            reorder_reg    <= '0;
            dup_reg        <= '0;
            pkt_reg        <= '0;
            octet_reg      <= '0;
            prev_reg       <= '0;
            acc_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
            expected_reg   <= expected_next;
            first_reg      <= first_next;
            top_reg        <= top_next;
            lost_reg       <= lost_next;
            reorder_reg    <= reorder_next;
            dup_reg        <= dup_next;
            pkt_reg        <= pkt_next;
            octet_reg      <= octet_next;
            prev_reg       <= prev_next;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        reply_reg   <= reply_next;
        begin_reg   <= begin_next;
        counted_reg <= counted_next;
        cls_reg     <= cls_next;
        gap_reg     <= gap_next;
        mag_reg     <= mag_next;
        dec_reg     <= dec_next;
        jupd_reg    <= jupd_next;
    end

endmodule

// ===== rtl/core/ulj_resq.sv =====
module ulj_resq
    import ulj_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res_data,
    output logic    res_full,
    output logic    empty,
    input  logic    pop,
    output result_t result
);

    result_t             rq_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0] wr_reg, wr_next;
    logic [RQ_PTR_W-1:0] rd_reg, rd_next;
    logic [RQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign res_full = (cnt_reg == RQ_CNT_W'(RQ_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;
    assign result   = rq_mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            rq_mem[wr_reg] <= res_data;
        end
    end

endmodule

// ===== bench/tb_udp_receive_loss_jitter_monitor.sv =====
`timescale 1ns / 1ps

module tb_udp_receive_loss_jitter_monitor;
    import ulj_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    in_item_t             item = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    udp_receive_loss_jitter_monitor DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // mirror of the monitor's configuration and statistics
    bit          is_server;
    bit          stream_tx;
    bit          seen_first;
    logic [31:0] next_expected = '0;
    logic [31:0] base_seq = '0;
    logic [31:0] peak_seq = '0;
    logic [31:0] lost_n = '0;
    logic [31:0] late_n = '0;
    logic [31:0] dup_n = '0;
    logic [63:0] dgram_n = '0;
    logic [63:0] octets_n = '0;
    logic [63:0] last_transit = '0;
    logic [39:0] jit_acc = '0;

    result_t due_stats[$];

    // traffic shaping
    logic [63:0] sender_us = 64'd0;
    logic [63:0] path_delay = 64'd0;
    bit          offering;
    bit          steady_feed;
    bit          steady_drain;
    int          burst_left;
    int          hold_off_request;
    int          hold_left;
    int          drain_mode;
    int          mode_left;
    logic [7:0]  pop_pattern;

    int mismatches;
    int datagrams_sent;
    int counted_seen;
    int results_checked;
    int quiet_cycles;

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic bit carries_word(input logic [31:0] w, input logic [31:0] key);
        return (w == key) || (byte_reverse(w) == key);
    endfunction

    function automatic logic [31:0] add_sat32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // advance the statistics by one accepted datagram and queue what it should report
    task automatic account_datagram(input in_item_t d);
        result_t     r;
        logic [63:0] sent_ns;
        logic [63:0] transit;
        logic [63:0] diff;
        logic [63:0] mag;
        logic [63:0] acc;
        logic [31:0] seq;
        r = '0;
        seq = d.sequence_req;
        if (is_server)
        begin
            if (d.length >= MIN_WORD_LEN && carries_word(d.first_word, CONNECT_WORD))
                r.send_reply = 1'b1;
        end
        else if (d.length >= MIN_WORD_LEN && carries_word(d.first_word, REPLY_WORD))
        begin
            r.begin_sending = 1'b1;
        end

        if (!r.send_reply && !r.begin_sending && !stream_tx && !d.omitting
            && d.length >= MIN_COUNT_LEN)
        begin
            r.counted = 1'b1;
            counted_seen++;
            octets_n = octets_n + {48'd0, d.length};
            dgram_n = dgram_n + 64'd1;
            if (!seen_first)
            begin
                seen_first = 1'b1;
                base_seq = seq;
                next_expected = seq;
            end
            if (seq > peak_seq)
                peak_seq = seq;

            if (seq == next_expected)
            begin
                r.class_code = CLS_IN_ORDER;
                next_expected = seq + 32'd1;
            end
            else if (seq > next_expected)
            begin
                r.class_code = CLS_GAP;
                lost_n = add_sat32(lost_n, seq - next_expected);
                next_expected = seq + 32'd1;
            end
            else if (lost_n != 32'd0)
            begin
                r.class_code = CLS_FILL;
                lost_n = lost_n - 32'd1;
                late_n = add_sat32(late_n, 32'd1);
            end
            else
            begin
                r.class_code = CLS_DUP;
                dup_n = add_sat32(dup_n, 32'd1);
            end

            sent_ns = {32'd0, d.sent_seconds} * 64'd1000000000
                    + {32'd0, d.sent_micros} * 64'd1000;
            transit = d.arrival_ns - sent_ns;
            if (dgram_n > 64'd1)
            begin
                diff = transit - last_transit;
                mag = diff[63] ? -diff : diff;
                if (mag > {24'd0, ACC_MAX})
                    mag = {24'd0, ACC_MAX};
                acc = {24'd0, jit_acc} - {28'd0, jit_acc[39:4]} + mag;
                jit_acc = (acc > {24'd0, ACC_MAX}) ? ACC_MAX : acc[39:0];
            end
            last_transit = transit;
        end

        r.lost_total = lost_n;
        r.reorder_total = late_n;
        r.duplicate_total = dup_n;
        r.packet_total = dgram_n;
        r.byte_total = octets_n;
        r.jitter_ns = (jit_acc[39:36] != 4'd0) ? 32'hFFFF_FFFF : jit_acc[35:4];
        r.first_sequence = base_seq;
        r.highest_sequence = peak_seq;
        due_stats.push_back(r);
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void compare_result(input result_t want, input result_t got);
        check_field("send_reply", 64'(want.send_reply), 64'(got.send_reply));
        check_field("begin_sending", 64'(want.begin_sending), 64'(got.begin_sending));
        check_field("counted", 64'(want.counted), 64'(got.counted));
        check_field("class_code", 64'(want.class_code), 64'(got.class_code));
        check_field("lost_total", 64'(want.lost_total), 64'(got.lost_total));
        check_field("reorder_total", 64'(want.reorder_total), 64'(got.reorder_total));
        check_field("duplicate_total", 64'(want.duplicate_total),
                    64'(got.duplicate_total));
        check_field("packet_total", want.packet_total, got.packet_total);
        check_field("byte_total", want.byte_total, got.byte_total);
        check_field("jitter_ns", 64'(want.jitter_ns), 64'(got.jitter_ns));
        check_field("first_sequence", 64'(want.first_sequence), 64'(got.first_sequence));
        check_field("highest_sequence", 64'(want.highest_sequence),
                    64'(got.highest_sequence));
    endfunction

    // result side: check every popped result, then pick the next pop
    always @(posedge clk)
    begin : drain
        result_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (due_stats.size() == 0)
                begin
                    $error("result popped with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = due_stats.pop_front();
                    compare_result(want, result);
                    results_checked++;
                end
            end
            if (hold_off_request > 0)
            begin
                hold_left = hold_off_request;
                hold_off_request = 0;
            end
            if (mode_left == 0)
            begin
                drain_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 160);
                pop_pattern = 8'($urandom);
            end
            mode_left--;
            pop_pattern = {pop_pattern[6:0], pop_pattern[7]};
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (steady_drain || drain_mode == 0)
                pop <= 1'b1;
            else if (drain_mode == 1)
                pop <= 1'($urandom_range(0, 1));
            else if (drain_mode == 2)
                pop <= ($urandom_range(0, 3) == 0);
            else
                pop <= pop_pattern[0];
        end
    end

    // end the run when no handshake of any kind happens for too long
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_datagram(input in_item_t d);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_feed ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                if (offering)
                    push <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push <= 1'b1;
        item <= d;
        offering = 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        burst_left--;
        datagrams_sent++;
        account_datagram(d);
    endtask

    task automatic stop_sending();
        if (offering)
            push <= 1'b0;
        offering = 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_idle();
        stop_sending();
        while (due_stats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // only bit 0 of the data carries the setting; upper bits get junk
    task automatic configure(input logic [CFG_IDX_W-1:0] idx, input bit val);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= {junk[31:1], val};
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SERVER_ROLE:   is_server = val;
            REG_SENDER_STREAM: stream_tx = val;
            default: ;
        endcase
    endtask

    function automatic in_item_t timed_datagram(input logic [31:0] seq,
                                                input logic [31:0] word,
                                                input logic [15:0] len,
                                                input bit omit);
        in_item_t d;
        sender_us = sender_us + 64'($urandom_range(5, 3000));
        d.first_word = word;
        d.length = len;
        d.sent_seconds = 32'(sender_us / 64'd1000000);
        d.sent_micros = 32'(sender_us % 64'd1000000);
        d.sequence_req = seq;
        d.arrival_ns = sender_us * 64'd1000 + path_delay + 64'($urandom_range(0, 80000));
        d.omitting = omit;
        return d;
    endfunction

    function automatic in_item_t noise_datagram(input bit keep_out);
        in_item_t d;
        d.first_word = $urandom;
        if ($urandom_range(0, 1))
            d.length = 16'($urandom_range(0, 15));
        else
            d.length = 16'($urandom_range(0, 65535));
        d.sent_seconds = $urandom;
        d.sent_micros = $urandom;
        d.sequence_req = $urandom;
        d.arrival_ns = {$urandom, $urandom};
        d.omitting = 1'($urandom_range(0, 1));
        if (keep_out && d.length >= MIN_COUNT_LEN)
            d.omitting = 1'b1;
        return d;
    endfunction

    function automatic logic [15:0] random_length();
        if ($urandom_range(0, 49) == 0)
            return 16'hFFFF;
        return 16'($urandom_range(16, 1500));
    endfunction

    // mostly in-order traffic with swaps, repeats, optional losses and stray words
    task automatic run_stream(input int count, input bit with_loss);
        int          sent;
        int          pick;
        logic [31:0] seq;
        logic [31:0] w;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            seq = next_expected;
            if (pick < 8)
            begin
                send_datagram(timed_datagram(seq + 32'd1, $urandom, random_length(), 1'b0));
                send_datagram(timed_datagram(seq, $urandom, random_length(), 1'b0));
                sent += 2;
            end
            else if (pick < 12)
            begin
                seq = seq - 32'd1 - 32'($urandom_range(0, 2));
                send_datagram(timed_datagram(seq, $urandom, random_length(), 1'b0));
                sent++;
            end
            else if (with_loss && pick < 16)
            begin
                seq = seq + 32'($urandom_range(2, 6));
                send_datagram(timed_datagram(seq, $urandom, random_length(), 1'b0));
                sent++;
            end
            else if (pick < 20)
            begin
                send_datagram(noise_datagram(1'b1));
                sent++;
            end
            else if (pick < 24)
            begin
                w = $urandom_range(0, 1) ? CONNECT_WORD : REPLY_WORD;
                if ($urandom_range(0, 1))
                    w = byte_reverse(w);
                send_datagram(timed_datagram(seq, w, 16'($urandom_range(0, 40)), 1'b0));
                sent++;
            end
            else
            begin
                send_datagram(timed_datagram(seq, $urandom, random_length(),
                                             $urandom_range(0, 49) == 0));
                sent++;
            end
        end
    endtask

    task automatic test_client_control_words();
        configure(REG_SERVER_ROLE, 1'b0);
        configure(REG_SENDER_STREAM, 1'b0);
        send_datagram(timed_datagram(32'd7, REPLY_WORD, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'd8, byte_reverse(REPLY_WORD), 16'd4, 1'b0));
        send_datagram(timed_datagram(32'd9, REPLY_WORD, 16'd3, 1'b0));
        // connect word means nothing to a client: first counted datagram
        send_datagram(timed_datagram(32'd100, CONNECT_WORD, 16'd16, 1'b0));
    endtask

    task automatic test_sequence_classes();
        send_datagram(timed_datagram(32'd101, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'd104, 32'h0, 16'd20, 1'b0));
        send_datagram(timed_datagram(32'd102, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'd103, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'd103, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'd105, 32'h0, 16'd15, 1'b0));
        send_datagram(timed_datagram(32'd105, 32'h0, 16'd64, 1'b1));
        send_datagram(timed_datagram(32'd105, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
        send_datagram(timed_datagram(32'd0, 32'h0, 16'd16, 1'b0));
    endtask

    task automatic test_jitter_extremes();
        in_item_t d;
        d = timed_datagram(32'd106, 32'h0, 16'd16, 1'b0);
        d.sent_seconds = 32'd0;
        d.sent_micros = 32'd0;
        d.arrival_ns = 64'd0;
        send_datagram(d);
        // transit jumps by 2^63: magnitude clips and the accumulator saturates
        d.sequence_req = 32'd107;
        d.arrival_ns = 64'h8000_0000_0000_0000;
        send_datagram(d);
        d.sequence_req = 32'd108;
        d.sent_seconds = 32'hFFFF_FFFF;
        d.sent_micros = 32'hFFFF_FFFF;
        d.arrival_ns = 64'hFFFF_FFFF_FFFF_FFFF;
        send_datagram(d);
        send_datagram(timed_datagram(32'd109, 32'h0, 16'd16, 1'b0));
    endtask

    task automatic test_server_role();
        configure(REG_SERVER_ROLE, 1'b1);
        send_datagram(timed_datagram(32'd500, CONNECT_WORD, 16'd4, 1'b0));
        send_datagram(timed_datagram(32'd501, byte_reverse(CONNECT_WORD), 16'd100, 1'b0));
        send_datagram(timed_datagram(32'd502, CONNECT_WORD, 16'd3, 1'b0));
        send_datagram(timed_datagram(32'd110, REPLY_WORD, 16'd16, 1'b0));
        configure(REG_SENDER_STREAM, 1'b1);
        send_datagram(timed_datagram(32'd111, 32'h0, 16'd64, 1'b0));
        send_datagram(timed_datagram(32'd112, CONNECT_WORD, 16'd16, 1'b0));
        configure(REG_SENDER_STREAM, 1'b0);
        configure(REG_SERVER_ROLE, 1'b0);
    endtask

    task automatic test_random_traffic();
        path_delay = {$urandom, $urandom};
        run_stream(500, 1'b0);
        configure(REG_SERVER_ROLE, 1'b1);
        run_stream(450, 1'b1);
        configure(REG_SENDER_STREAM, 1'b1);
        run_stream(100, 1'b1);
        configure(REG_SENDER_STREAM, 1'b0);
        configure(REG_SERVER_ROLE, 1'b0);
        steady_feed = 1'b1;
        steady_drain = 1'b1;
        run_stream(300, 1'b1);
        steady_feed = 1'b0;
        steady_drain = 1'b0;
    endtask

    task automatic test_input_backpressure();
        wait_idle();
        steady_feed = 1'b1;
        hold_off_request = 150;
        run_stream(40, 1'b0);
        steady_feed = 1'b0;
    endtask

    task automatic test_wrap_and_saturation();
        configure(REG_SERVER_ROLE, 1'b0);
        configure(REG_SENDER_STREAM, 1'b0);
        send_datagram(timed_datagram(32'hFFFF_FFFF, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'h0, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'hFFFF_FFF0, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'd5, 32'h0, 16'd16, 1'b0));
        send_datagram(timed_datagram(32'hFFFF_FFF8, 32'h0, 16'd16, 1'b0));
    endtask

    task automatic test_random_fields();
        configure(REG_SERVER_ROLE, 1'b1);
        repeat (80) send_datagram(noise_datagram(1'b0));
        configure(REG_SERVER_ROLE, 1'b0);
        repeat (80) send_datagram(noise_datagram(1'b0));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_client_control_words();
        test_sequence_classes();
        test_jitter_extremes();
        test_server_role();
        test_random_traffic();
        test_input_backpressure();
        test_wrap_and_saturation();
        test_random_fields();
        stop_sending();
        while (due_stats.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        $display("Sent %0d datagrams, %0d entered the statistics, %0d results checked;",
                 datagrams_sent, counted_seen, results_checked);
        $display("both roles, sender stream mode, sequence wrap and counter and jitter limits.");
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ulj_pkg.sv
rtl/core/ulj_front.sv
rtl/core/ulj_back.sv
rtl/core/ulj_resq.sv
rtl/core/udp_receive_loss_jitter_monitor.sv
bench/tb_udp_receive_loss_jitter_monitor.sv
